// ----- rtl/core/iida_pkg.sv -----
// shared types and constants for the indexed insert/delete array
package iida_pkg;

    // fixed field widths
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 7;
    localparam int VAL_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_PUSH   = 3'd1,
        CMD_GET    = 3'd2,
        CMD_POP    = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_GET_WAIT,
        S_RESP
    } state_t;

endpackage

// ----- rtl/core/indexed_insert_delete_array.sv -----
// top level: bounded ordered word array with insert, push, get, pop and delete
//
// Each item on the s_ side is one command (s_tuser) with an index and a word;
// each produces exactly one result item on the m_ side with a status, the word
// read by a get (zero otherwise) and the element count after the command.
// s_tready is high only while the sequencer is idle; one command is worked at
// a time. Push writes its word on accept and pop only lowers the count; get
// reads the memory and waits for the registered read data. Insert moves the
// words from the index to the end one place up, then writes the new word into
// the opened slot; delete moves the words after the index one place down. The
// words go one at a time through the single read and single write port of the
// element memory.
// Results sit in an output register; a stalled m_tready holds it, and the next
// result waits in the sequencer until that register frees up, while s_tready
// stays low. Reset clears the element count; memory contents are left as is
// and are never read before being written.
module indexed_insert_delete_array #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [iida_pkg::IN_DATA_W-1:0]      s_tdata,   // index[6:0], value[38:7], pad
    input  logic [iida_pkg::CMD_W-1:0]          s_tuser,   // command[2:0]
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [iida_pkg::OUT_DATA_W-1:0]     m_tdata,   // read_value[31:0], count[38:32], pad
    output logic [iida_pkg::STATUS_W-1:0]       m_tuser    // status[1:0]
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic                            start;
    logic                            idle;
    logic                            res_valid;
    logic                            res_ready;
    logic [iida_pkg::STATUS_W-1:0]   res_status;
    logic [iida_pkg::VAL_W-1:0]      res_read_value;
    logic [iida_pkg::COUNT_W-1:0]    res_count;
    logic                            mem_we;
    logic [ADDR_W-1:0]               mem_waddr;
    logic [iida_pkg::VAL_W-1:0]      mem_wdata;
    logic                            mem_re;
    logic [ADDR_W-1:0]               mem_raddr;
    logic [iida_pkg::VAL_W-1:0]      mem_rdata;

    logic                            m_valid_reg, m_valid_next;
    logic [iida_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [iida_pkg::STATUS_W-1:0]   m_user_reg, m_user_next;

    assign s_tready = idle;
    assign start    = s_tvalid & idle;

    iida_seq #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .cmd            (s_tuser),
        .idx            (s_tdata[iida_pkg::IDX_W-1:0]),
        .val            (s_tdata[iida_pkg::IDX_W +: iida_pkg::VAL_W]),
        .idle           (idle),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_status     (res_status),
        .res_read_value (res_read_value),
        .res_count      (res_count),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    iida_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W),
        .WIDTH  (iida_pkg::VAL_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    assign res_ready = ~m_valid_reg | m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_data_next  = iida_pkg::OUT_DATA_W'({res_count, res_read_value});
            m_user_next  = res_status;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- rtl/core/iida_mem.sv -----
// element storage: one write port and one registered read port
module iida_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/iida_seq.sv -----
// command sequencer: range checks, element count and one-word-per-cycle shifting
module iida_seq #(
    parameter int CAPACITY = 64,
    parameter int ADDR_W   = 6,
    parameter int CNT_W    = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command side
    input  logic                          start,
    input  logic [iida_pkg::CMD_W-1:0]    cmd,
    input  logic [iida_pkg::IDX_W-1:0]    idx,
    input  logic [iida_pkg::VAL_W-1:0]    val,
    output logic                          idle,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [iida_pkg::STATUS_W-1:0] res_status,
    output logic [iida_pkg::VAL_W-1:0]    res_read_value,
    output logic [iida_pkg::COUNT_W-1:0]  res_count,
    // memory port
    output logic                          mem_we,
    output logic [ADDR_W-1:0]             mem_waddr,
    output logic [iida_pkg::VAL_W-1:0]    mem_wdata,
    output logic                          mem_re,
    output logic [ADDR_W-1:0]             mem_raddr,
    input  logic [iida_pkg::VAL_W-1:0]    mem_rdata
);

    // compare width covering both the index field and the count
    localparam int EXT_W = (CNT_W > iida_pkg::IDX_W) ? CNT_W : iida_pkg::IDX_W;

    iida_pkg::state_t                state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [ADDR_W-1:0]               ptr_reg, ptr_next;
    logic [ADDR_W-1:0]               end_reg, end_next;
    logic [ADDR_W-1:0]               paddr_reg, paddr_next;
    logic [ADDR_W-1:0]               place_reg, place_next;
    logic                            up_reg, up_next;
    logic                            reading_reg, reading_next;
    logic                            pend_reg, pend_next;
    logic [iida_pkg::VAL_W-1:0]      val_reg, val_next;
    logic [iida_pkg::VAL_W-1:0]      rd_reg, rd_next;
    logic [iida_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic [EXT_W-1:0]                idx_e;
    logic [EXT_W-1:0]                cnt_e;
    logic [ADDR_W-1:0]               idx_a;
    logic [ADDR_W-1:0]               last_a;
    logic                            full;

    assign idx_e  = EXT_W'(idx);
    assign cnt_e  = EXT_W'(count_reg);
    assign idx_a  = idx_e[ADDR_W-1:0];
    assign last_a = ADDR_W'(count_reg - CNT_W'(1));
    assign full   = (count_reg == CNT_W'(CAPACITY));

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= iida_pkg::S_IDLE;
            count_reg   <= '0;
            reading_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            reading_reg <= reading_next;
            pend_reg    <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        end_reg    <= end_next;
        paddr_reg  <= paddr_next;
        place_reg  <= place_next;
        up_reg     <= up_next;
        val_reg    <= val_next;
        rd_reg     <= rd_next;
        status_reg <= status_next;
    end

    // next state, memory control and shift stepping
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        end_next     = end_reg;
        paddr_next   = paddr_reg;
        place_next   = place_reg;
        up_next      = up_reg;
        reading_next = reading_reg;
        pend_next    = pend_reg;
        val_next     = val_reg;
        rd_next      = rd_reg;
        status_next  = status_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        idle         = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            iida_pkg::S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    rd_next      = '0;
                    status_next  = iida_pkg::ST_OK;
                    state_next   = iida_pkg::S_RESP;
                    reading_next = 1'b1;
                    pend_next    = 1'b0;
                    case (cmd)
                        iida_pkg::CMD_INSERT:
                        begin
                            if (idx_e > cnt_e)
                            begin
                                status_next = iida_pkg::ST_INDEX;
                            end
                            else if (full)
                            begin
                                status_next = iida_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                val_next   = val;
                                place_next = idx_a;
                                up_next    = 1'b1;
                                ptr_next   = last_a;
                                end_next   = idx_a;
                                state_next = (idx_e == cnt_e) ? iida_pkg::S_PLACE
                                                              : iida_pkg::S_SHIFT;
                            end
                        end
                        iida_pkg::CMD_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = iida_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = ADDR_W'(count_reg);
                                mem_wdata  = val;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        iida_pkg::CMD_GET:
                        begin
                            if (idx_e >= cnt_e)
                            begin
                                status_next = iida_pkg::ST_INDEX;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = idx_a;
                                state_next = iida_pkg::S_GET_WAIT;
                            end
                        end
                        iida_pkg::CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = iida_pkg::ST_INDEX;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        iida_pkg::CMD_DELETE:
                        begin
                            if (idx_e >= cnt_e)
                            begin
                                status_next = iida_pkg::ST_INDEX;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                up_next    = 1'b0;
                                ptr_next   = ADDR_W'(idx_a + ADDR_W'(1));
                                end_next   = last_a;
                                if (idx_a != last_a)
                                begin
                                    state_next = iida_pkg::S_SHIFT;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = iida_pkg::ST_INDEX;
                        end
                    endcase
                end
            end

            // read one word per cycle, write the word read last cycle one place over
            iida_pkg::S_SHIFT:
            begin
                if (reading_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg;
                    if (ptr_reg == end_reg)
                    begin
                        reading_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = up_reg ? ADDR_W'(ptr_reg - ADDR_W'(1))
                                          : ADDR_W'(ptr_reg + ADDR_W'(1));
                    end
                end
                pend_next  = reading_reg;
                paddr_next = ptr_reg;
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = up_reg ? ADDR_W'(paddr_reg + ADDR_W'(1))
                                       : ADDR_W'(paddr_reg - ADDR_W'(1));
                    mem_wdata = mem_rdata;
                    if (!reading_reg)
                    begin
                        state_next = up_reg ? iida_pkg::S_PLACE : iida_pkg::S_RESP;
                    end
                end
            end

            // drop the new word into the opened slot
            iida_pkg::S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = place_reg;
                mem_wdata  = val_reg;
                state_next = iida_pkg::S_RESP;
            end

            iida_pkg::S_GET_WAIT:
            begin
                rd_next    = mem_rdata;
                state_next = iida_pkg::S_RESP;
            end

            iida_pkg::S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = iida_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = iida_pkg::S_IDLE;
            end
        endcase
    end

    assign res_status     = status_reg;
    assign res_read_value = rd_reg;
    assign res_count      = iida_pkg::COUNT_W'(count_reg);

endmodule

// ----- dv/iida_array_checker.sv -----
`timescale 1ns / 1ps
// scoreboard for the indexed insert/delete array: predicts each result item and checks it
module iida_array_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [iida_pkg::IN_DATA_W-1:0]      s_tdata,   // index[6:0], value[38:7], pad
    input  logic [iida_pkg::CMD_W-1:0]          s_tuser,   // command[2:0]
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [iida_pkg::OUT_DATA_W-1:0]     m_tdata,   // read_value[31:0], count[38:32], pad
    input  logic [iida_pkg::STATUS_W-1:0]       m_tuser,   // status[1:0]
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  fill_level
);

    typedef struct packed {
        iida_pkg::status_t                status;
        logic [iida_pkg::VAL_W-1:0]       read_value;
        logic [iida_pkg::COUNT_W-1:0]     count;
    } array_result_t;

    // shadow copy of the array contents and its element count
    logic [iida_pkg::VAL_W-1:0] words [CAPACITY];
    int                         held;
    array_result_t              expected_results [$];

    // apply one command to the shadow array and return the result it should give
    function automatic array_result_t apply_command(input logic [iida_pkg::CMD_W-1:0] cmd,
                                                    input logic [iida_pkg::IDX_W-1:0] idx,
                                                    input logic [iida_pkg::VAL_W-1:0] val);
        array_result_t res;
        int            i;
        res.status     = iida_pkg::ST_OK;
        res.read_value = '0;
        case (cmd)
            iida_pkg::CMD_INSERT:
            begin
                if (int'(idx) > held)
                    res.status = iida_pkg::ST_INDEX;
                else if (held >= CAPACITY)
                    res.status = iida_pkg::ST_FULL;
                else
                begin
                    for (i = held; i > int'(idx); i--)
                        words[i] = words[i-1];
                    words[idx] = val;
                    held++;
                end
            end
            iida_pkg::CMD_PUSH:
            begin
                if (held >= CAPACITY)
                    res.status = iida_pkg::ST_FULL;
                else
                begin
                    words[held] = val;
                    held++;
                end
            end
            iida_pkg::CMD_GET:
            begin
                if (int'(idx) >= held)
                    res.status = iida_pkg::ST_INDEX;
                else
                    res.read_value = words[idx];
            end
            iida_pkg::CMD_POP:
            begin
                if (held == 0)
                    res.status = iida_pkg::ST_INDEX;
                else
                    held--;
            end
            iida_pkg::CMD_DELETE:
            begin
                if (int'(idx) >= held)
                    res.status = iida_pkg::ST_INDEX;
                else
                begin
                    for (i = int'(idx); i + 1 < held; i++)
                        words[i] = words[i+1];
                    held--;
                end
            end
            default:
                res.status = iida_pkg::ST_INDEX;
        endcase
        res.count = iida_pkg::COUNT_W'(held);
        return res;
    endfunction

    // count a mismatch, print only the first few
    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // compare finished items first, then record the expectation of a newly accepted one
    always @(posedge clk or negedge rst_n)
    begin
        array_result_t got;
        array_result_t want;
        if (!rst_n)
        begin
            held = 0;
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status     = iida_pkg::status_t'(m_tuser);
                got.read_value = m_tdata[iida_pkg::VAL_W-1:0];
                got.count      = m_tdata[iida_pkg::VAL_W +: iida_pkg::COUNT_W];
                if (expected_results.size() == 0)
                    note_mismatch($sformatf({"result with nothing outstanding: ",
                                             "status %0d value %h count %0d"},
                                            got.status, got.read_value, got.count));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.read_value !== want.read_value
                        || got.count !== want.count)
                        note_mismatch($sformatf({"expected status %0d value %h count %0d, ",
                                                 "got status %0d value %h count %0d"},
                                                want.status, want.read_value, want.count,
                                                got.status, got.read_value, got.count));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(
                    apply_command(s_tuser, s_tdata[iida_pkg::IDX_W-1:0],
                                  s_tdata[iida_pkg::IDX_W +: iida_pkg::VAL_W]));
        end
        outstanding = expected_results.size();
        fill_level  = held;
    end

endmodule

// ----- dv/tb_indexed_insert_delete_array.sv -----
`timescale 1ns / 1ps
// testbench top for the indexed insert/delete array: stimulus, stalls and verdict
module tb_indexed_insert_delete_array;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1880;
    localparam int IDLE_PERCENT = 29;
    localparam logic [iida_pkg::CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [iida_pkg::CMD_W-1:0] CMD_MID_UNUSED   = 3'd6;
    localparam logic [iida_pkg::CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [iida_pkg::IN_DATA_W-1:0]    s_tdata  = '0;
    logic [iida_pkg::CMD_W-1:0]        s_tuser  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [iida_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic [iida_pkg::STATUS_W-1:0]     m_tuser;

    int mismatches;
    int outstanding;
    int fill_level;
    bit no_stall = 1'b0;
    bit growing  = 1'b1;

    always #4 clk = ~clk;

    indexed_insert_delete_array #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    iida_array_checker #(
        .CAPACITY (CAPACITY)
    ) checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .fill_level  (fill_level)
    );

    // result side back-pressure
    always @(negedge clk)
        m_tready <= no_stall || ($urandom_range(99) >= IDLE_PERCENT);

    // pick a random command, steering the fill level between empty and full
    function automatic void choose_command(output logic [iida_pkg::CMD_W-1:0] cmd,
                                           output logic [iida_pkg::IDX_W-1:0] idx,
                                           output logic [iida_pkg::VAL_W-1:0] val);
        int lvl;
        int pick;
        int spot;
        lvl  = fill_level;
        if (lvl >= CAPACITY && $urandom_range(7) == 0)
            growing = 1'b0;
        else if (lvl == 0 && $urandom_range(3) == 0)
            growing = 1'b1;
        else if ($urandom_range(99) == 0)
            growing = !growing;
        pick = $urandom_range(99);
        if (growing)
            cmd = (pick < 35) ? iida_pkg::CMD_PUSH : (pick < 65) ? iida_pkg::CMD_INSERT :
                  (pick < 80) ? iida_pkg::CMD_GET : (pick < 87) ? iida_pkg::CMD_POP :
                  iida_pkg::CMD_DELETE;
        else
            cmd = (pick < 8) ? iida_pkg::CMD_PUSH : (pick < 18) ? iida_pkg::CMD_INSERT :
                  (pick < 38) ? iida_pkg::CMD_GET : (pick < 65) ? iida_pkg::CMD_POP :
                  iida_pkg::CMD_DELETE;
        // index at the edges of the occupied range, anywhere inside it, or sometimes anywhere
        spot = $urandom_range(9);
        case (spot)
            0:       idx = '0;
            1:       idx = iida_pkg::IDX_W'(lvl);
            2:       idx = (lvl > 0) ? iida_pkg::IDX_W'(lvl - 1) : '0;
            3:       idx = iida_pkg::IDX_W'($urandom_range(127));
            default:
            begin
                if (cmd == iida_pkg::CMD_INSERT)
                    idx = iida_pkg::IDX_W'($urandom_range(lvl));
                else
                    idx = (lvl > 0) ? iida_pkg::IDX_W'($urandom_range(lvl - 1)) : '0;
            end
        endcase
        // noise: any code, unused ones included, with any index
        if (pick >= 95)
        begin
            cmd = iida_pkg::CMD_W'($urandom_range(CMD_LAST_UNUSED));
            idx = iida_pkg::IDX_W'($urandom_range(127));
        end
        val = $urandom;
    endfunction

    // offer one item after random idle cycles and wait for it to be taken
    task automatic send_item(input bit pick_random, input logic [iida_pkg::CMD_W-1:0] cmd,
                             input logic [iida_pkg::IDX_W-1:0] idx,
                             input logic [iida_pkg::VAL_W-1:0] val);
        logic [iida_pkg::CMD_W-1:0] c;
        logic [iida_pkg::IDX_W-1:0] x;
        logic [iida_pkg::VAL_W-1:0] v;
        while (!no_stall && $urandom_range(99) < IDLE_PERCENT)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        c = cmd;
        x = idx;
        v = val;
        if (pick_random)
            choose_command(c, x, v);
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {1'b0, v, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // run time limit
    initial
    begin
        #(10_000_000);
        $display("indexed_insert_delete_array verification failed");
        $finish;
    end

    initial
    begin
        int n;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty array, extremes, middle and end positions, unused codes
        send_item(0, iida_pkg::CMD_POP,    7'd0,   32'h0000_0000);
        send_item(0, iida_pkg::CMD_GET,    7'd0,   32'h0000_0000);
        send_item(0, iida_pkg::CMD_DELETE, 7'd0,   32'h0000_0000);
        send_item(0, iida_pkg::CMD_INSERT, 7'd1,   32'h1111_1111);
        send_item(0, iida_pkg::CMD_INSERT, 7'd127, 32'h2222_2222);
        send_item(0, iida_pkg::CMD_INSERT, 7'd0,   32'h8000_0000);
        send_item(0, iida_pkg::CMD_PUSH,   7'd127, 32'h7fff_ffff);
        send_item(0, iida_pkg::CMD_PUSH,   7'd0,   32'hffff_ffff);
        send_item(0, iida_pkg::CMD_PUSH,   7'd0,   32'h0000_0000);
        send_item(0, iida_pkg::CMD_INSERT, 7'd2,   32'h5a5a_5a5a);
        send_item(0, iida_pkg::CMD_INSERT, 7'd5,   32'h1234_5678);
        send_item(0, iida_pkg::CMD_GET,    7'd0,   32'hffff_ffff);
        send_item(0, iida_pkg::CMD_GET,    7'd2,   32'h0000_0000);
        send_item(0, iida_pkg::CMD_GET,    7'd5,   32'h0000_0000);
        send_item(0, iida_pkg::CMD_GET,    7'd6,   32'h0000_0000);
        send_item(0, iida_pkg::CMD_GET,    7'd127, 32'h0000_0000);
        send_item(0, iida_pkg::CMD_DELETE, 7'd2,   32'h0000_0000);
        send_item(0, iida_pkg::CMD_DELETE, 7'd4,   32'h0000_0000);
        send_item(0, iida_pkg::CMD_DELETE, 7'd127, 32'h0000_0000);
        send_item(0, CMD_FIRST_UNUSED,     7'd0,   32'h0000_0000);
        send_item(0, CMD_MID_UNUSED,       7'd1,   32'hffff_ffff);
        send_item(0, CMD_LAST_UNUSED,      7'd127, 32'h8000_0000);
        send_item(0, iida_pkg::CMD_POP,    7'd0,   32'h0000_0000);
        send_item(0, iida_pkg::CMD_GET,    7'd0,   32'h0000_0000);
        send_item(0, iida_pkg::CMD_DELETE, 7'd0,   32'h0000_0000);

        // random: fill first so the full cases come early, with one stretch of no stalls
        growing = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_stall = (n >= 900 && n < 1300);
            send_item(1, iida_pkg::CMD_PUSH, '0, '0);
        end
        no_stall = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain until every expected result has been received, then wait before the verdict
        while (outstanding != 0)
            @(negedge clk);
        repeat (2 * CAPACITY + 16) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("indexed_insert_delete_array verification clean");
        else
            $display("indexed_insert_delete_array verification failed");
        $finish;
    end

endmodule
